/* sv/d2yp_pkg.sv */
// ----------------------------------------------------------------------------
// d2yp_pkg
// Shared constants, types and the arctangent table for the yaw/pitch pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package d2yp_pkg;

   localparam int COORD_WIDTH   = 32;
   localparam int CORDIC_STAGES = 24;

   localparam int TABLE_LEN  = 32;
   localparam int RUN_STAGES = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
   localparam int IDX_W      = $clog2(TABLE_LEN);

   // datapath: differences scaled so that every value fits 63 signed bits
   localparam int DATA_W     = 63;
   localparam int DIFF_W     = COORD_WIDTH + 1;
   localparam int GUARD_BITS = 59 - COORD_WIDTH;
   localparam int PAD_W      = DATA_W - DIFF_W - GUARD_BITS;

   // angles, Q.16 degrees
   localparam int ANG_W   = 26;
   localparam int YAW_W   = 26;
   localparam int PITCH_W = 24;

   localparam logic signed [ANG_W:0] DEG90     = (ANG_W + 1)'(5898240);
   localparam logic signed [ANG_W:0] YAW_MIN   = -(ANG_W + 1)'(17694720);
   localparam logic signed [ANG_W:0] YAW_MAX   = (ANG_W + 1)'(5898240);
   localparam logic signed [ANG_W:0] PITCH_LIM = (ANG_W + 1)'(5898240);

   // gain compensation: x * GAIN_INV / 2^GAIN_FRAC, round half up
   localparam int GAIN_W    = 29;
   localparam int GAIN_FRAC = 29;
   localparam int SPLIT     = 32;
   localparam int HI_W      = DATA_W - SPLIT;
   localparam int PHI_W     = HI_W + GAIN_W;
   localparam int PLO_W     = SPLIT + GAIN_W;
   localparam logic [GAIN_W-1:0] GAIN_INV = GAIN_W'(326016437);

   // stream widths
   localparam int NUM_IN = 6;
   localparam int REQ_W  = ((NUM_IN * COORD_WIDTH + 7) / 8) * 8;
   localparam int RSP_W  = ((YAW_W + PITCH_W + 7) / 8) * 8;

   // pipeline depth up to the output register
   localparam int PIPE_LEN = 2 * RUN_STAGES + 5;
   localparam int SIDE_LEN = RUN_STAGES + 3;

   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [ANG_W-1:0]  z;
      logic                     zero;
   } vec_type;

   typedef struct packed {
      logic signed [PITCH_W-1:0] pitch;
      logic signed [YAW_W-1:0]   yaw;
   } rsp_type;

   // round(atan(2^-i) in degrees * 2^16)
   function automatic logic signed [ANG_W-1:0] atan_deg(input logic [IDX_W-1:0] idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         5'd0:    v = ANG_W'(2949120);
         5'd1:    v = ANG_W'(1740967);
         5'd2:    v = ANG_W'(919879);
         5'd3:    v = ANG_W'(466945);
         5'd4:    v = ANG_W'(234379);
         5'd5:    v = ANG_W'(117304);
         5'd6:    v = ANG_W'(58666);
         5'd7:    v = ANG_W'(29335);
         5'd8:    v = ANG_W'(14668);
         5'd9:    v = ANG_W'(7334);
         5'd10:   v = ANG_W'(3667);
         5'd11:   v = ANG_W'(1833);
         5'd12:   v = ANG_W'(917);
         5'd13:   v = ANG_W'(458);
         5'd14:   v = ANG_W'(229);
         5'd15:   v = ANG_W'(115);
         5'd16:   v = ANG_W'(57);
         5'd17:   v = ANG_W'(29);
         5'd18:   v = ANG_W'(14);
         5'd19:   v = ANG_W'(7);
         5'd20:   v = ANG_W'(4);
         5'd21:   v = ANG_W'(2);
         5'd22:   v = ANG_W'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

/* sv/d2yp_prep.sv */
// ----------------------------------------------------------------------------
// d2yp_prep
// CORDIC entry stage: zero detect and quarter turn of left-half-plane vectors.
// ----------------------------------------------------------------------------
`default_nettype none

module d2yp_prep (
   input  wire logic                               clock,
   input  wire logic                               en,
   input  wire logic signed [d2yp_pkg::DATA_W-1:0] x_in,
   input  wire logic signed [d2yp_pkg::DATA_W-1:0] y_in,
   output d2yp_pkg::vec_type                       vec_ff
);

   d2yp_pkg::vec_type vec_in;

   always_comb begin
      vec_in.x    = x_in;
      vec_in.y    = y_in;
      vec_in.z    = '0;
      vec_in.zero = (x_in == '0) && (y_in == '0);
      if (x_in[d2yp_pkg::DATA_W-1]) begin
         if (!y_in[d2yp_pkg::DATA_W-1]) begin
            vec_in.x = y_in;
            vec_in.y = -x_in;
            vec_in.z = d2yp_pkg::DEG90[d2yp_pkg::ANG_W-1:0];
         end else begin
            vec_in.x = -y_in;
            vec_in.y = x_in;
            vec_in.z = -d2yp_pkg::DEG90[d2yp_pkg::ANG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff <= vec_in;
      end
   end

endmodule

`default_nettype wire

/* sv/d2yp_cell.sv */
// ----------------------------------------------------------------------------
// d2yp_cell
// One vectoring CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module d2yp_cell (
   input  wire logic                              clock,
   input  wire logic                              en,
   input  wire logic [d2yp_pkg::IDX_W-1:0]        idx,
   input  wire d2yp_pkg::vec_type                 vec_in,
   output d2yp_pkg::vec_type                      vec_ff
);

   logic signed [d2yp_pkg::DATA_W-1:0] xs;
   logic signed [d2yp_pkg::DATA_W-1:0] ys;
   logic signed [d2yp_pkg::ANG_W-1:0]  step;
   d2yp_pkg::vec_type                  nxt_in;

   always_comb begin
      xs   = vec_in.x >>> idx;   // floor shift
      ys   = vec_in.y >>> idx;
      step = d2yp_pkg::atan_deg(idx);
      nxt_in.zero = vec_in.zero;
      if (!vec_in.y[d2yp_pkg::DATA_W-1]) begin
         nxt_in.x = vec_in.x + ys;
         nxt_in.y = vec_in.y - xs;
         nxt_in.z = vec_in.z + step;
      end else begin
         nxt_in.x = vec_in.x - ys;
         nxt_in.y = vec_in.y + xs;
         nxt_in.z = vec_in.z - step;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff <= nxt_in;
      end
   end

endmodule

`default_nettype wire

/* sv/d2yp_gain.sv */
// ----------------------------------------------------------------------------
// d2yp_gain
// Two-stage CORDIC gain compensation: split multiply, then rounded sum.
// ----------------------------------------------------------------------------
`default_nettype none

module d2yp_gain (
   input  wire logic                               clock,
   input  wire logic                               en,
   input  wire logic signed [d2yp_pkg::DATA_W-1:0] mag,
   output logic signed [d2yp_pkg::DATA_W-1:0]      hyp_ff
);

   logic [d2yp_pkg::HI_W-1:0]          hi;
   logic [d2yp_pkg::SPLIT-1:0]         lo;
   logic [d2yp_pkg::PHI_W-1:0]         p_hi_in, p_hi_ff;
   logic [d2yp_pkg::PLO_W-1:0]         p_lo_in, p_lo_ff;
   logic signed [d2yp_pkg::DATA_W-1:0] hyp_in;

   // mag is never negative here
   assign hi = mag[d2yp_pkg::DATA_W-1:d2yp_pkg::SPLIT];
   assign lo = mag[d2yp_pkg::SPLIT-1:0];

   assign p_hi_in = {{d2yp_pkg::GAIN_W{1'b0}}, hi}
                  * {{d2yp_pkg::HI_W{1'b0}}, d2yp_pkg::GAIN_INV};
   assign p_lo_in = {{d2yp_pkg::GAIN_W{1'b0}}, lo}
                  * {{d2yp_pkg::SPLIT{1'b0}}, d2yp_pkg::GAIN_INV}
                  + (d2yp_pkg::PLO_W'(1) << (d2yp_pkg::GAIN_FRAC - 1));

   // high product weighs 2^(SPLIT-GAIN_FRAC) after the scale-down
   assign hyp_in = (d2yp_pkg::DATA_W'(p_hi_ff) <<< (d2yp_pkg::SPLIT - d2yp_pkg::GAIN_FRAC))
                 + d2yp_pkg::DATA_W'(p_lo_ff[d2yp_pkg::PLO_W-1:d2yp_pkg::GAIN_FRAC]);

   always_ff @(posedge clock) begin
      if (en) begin
         p_hi_ff <= p_hi_in;
         p_lo_ff <= p_lo_in;
         hyp_ff  <= hyp_in;
      end
   end

endmodule

`default_nettype wire

/* sv/direction_to_yaw_pitch_top.sv */
// ----------------------------------------------------------------------------
// direction_to_yaw_pitch_top
// Yaw and pitch of the direction between two Q16.16 points, two CORDIC chains.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake             payload
//  req      in   req_tvalid/tready     from_x,y,z, to_x,y,z (Q16.16, 32b each)
//  rsp      out  rsp_tvalid/tready     yaw_deg (26b), pitch_deg (24b), Q.16 deg
//
//  One item per cycle sustained while rsp_tready holds; the pipe depth is
//  set by the two chains of CORDIC cells plus the gain multiply stages.
//  Reset (synchronous) clears the stage valid bits, skid and output valid.
//  The whole pipe advances while the skid stage is empty; a stalled result
//  lets one more item move into the skid before req_tready drops.
//
`default_nettype none

module direction_to_yaw_pitch_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // from_x, from_y, from_z, to_x, to_y, to_z (lowest bit first)
   input  wire logic [d2yp_pkg::REQ_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // yaw_deg, pitch_deg (lowest bit first), zero fill on top
   output logic [d2yp_pkg::RSP_W-1:0]         rsp_tdata
);

   localparam int N  = d2yp_pkg::RUN_STAGES;
   localparam int W  = d2yp_pkg::COORD_WIDTH;
   localparam int DW = d2yp_pkg::DATA_W;
   localparam int AW = d2yp_pkg::ANG_W;

   logic en;

   // stage valid bits
   logic [d2yp_pkg::PIPE_LEN-1:0] valid_in, valid_ff;

   // difference stage
   logic signed [d2yp_pkg::DIFF_W-1:0] dx, dy, dz;
   logic signed [DW-1:0] dx_in, dy_in, dz_in;
   logic signed [DW-1:0] dx_ff, dy_ff, dz_ff;

   // side lines riding along the CORDIC chains
   logic signed [DW-1:0]                    dy_line_ff  [d2yp_pkg::SIDE_LEN];
   logic signed [d2yp_pkg::YAW_W-1:0]       yaw_line_ff [d2yp_pkg::SIDE_LEN];

   d2yp_pkg::vec_type c1 [N+1];
   d2yp_pkg::vec_type c2 [N+1];

   logic signed [DW-1:0] hyp;

   logic signed [AW-1:0] a1, a2;
   logic signed [AW:0]   yaw_full, pitch_full;
   logic signed [AW:0]   yaw_sat, pitch_sat;

   d2yp_pkg::rsp_type pipe_rsp;
   d2yp_pkg::rsp_type out_in, out_ff;
   d2yp_pkg::rsp_type skid_in, skid_ff;
   logic              rsp_tvalid_in, rsp_tvalid_ff;
   logic              skid_valid_in, skid_valid_ff;
   logic              pipe_valid;
   logic              out_hold;

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   // ---------------- differences, scaled into the datapath -----------------
   assign dx = d2yp_pkg::DIFF_W'($signed(req_tdata[3*W +: W]))
             - d2yp_pkg::DIFF_W'($signed(req_tdata[0*W +: W]));
   assign dy = d2yp_pkg::DIFF_W'($signed(req_tdata[4*W +: W]))
             - d2yp_pkg::DIFF_W'($signed(req_tdata[1*W +: W]));
   assign dz = d2yp_pkg::DIFF_W'($signed(req_tdata[5*W +: W]))
             - d2yp_pkg::DIFF_W'($signed(req_tdata[2*W +: W]));

   assign dx_in = {{d2yp_pkg::PAD_W{dx[d2yp_pkg::DIFF_W-1]}}, dx,
                   {d2yp_pkg::GUARD_BITS{1'b0}}};
   assign dy_in = {{d2yp_pkg::PAD_W{dy[d2yp_pkg::DIFF_W-1]}}, dy,
                   {d2yp_pkg::GUARD_BITS{1'b0}}};
   assign dz_in = {{d2yp_pkg::PAD_W{dz[d2yp_pkg::DIFF_W-1]}}, dz,
                   {d2yp_pkg::GUARD_BITS{1'b0}}};

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         dz_ff <= dz_in;
      end
   end

   // ---------------- first CORDIC: atan2(dz, dx) and |(dx,dz)| -------------
   d2yp_prep u_prep1 (
      .clock  (clock),
      .en     (en),
      .x_in   (dx_ff),
      .y_in   (dz_ff),
      .vec_ff (c1[0])
   );

   for (genvar i = 0; i < N; i++) begin : g_chain1
      d2yp_cell u_cell (
         .clock  (clock),
         .en     (en),
         .idx    (d2yp_pkg::IDX_W'(i)),
         .vec_in (c1[i]),
         .vec_ff (c1[i+1])
      );
   end

   // yaw settles right after the first chain; zero vector gives angle 0
   always_comb begin
      a1       = c1[N].zero ? '0 : c1[N].z;
      yaw_full = (AW + 1)'(a1) - d2yp_pkg::DEG90;
      if (yaw_full < d2yp_pkg::YAW_MIN) begin
         yaw_sat = d2yp_pkg::YAW_MIN;
      end else if (yaw_full > d2yp_pkg::YAW_MAX) begin
         yaw_sat = d2yp_pkg::YAW_MAX;
      end else begin
         yaw_sat = yaw_full;
      end
   end

   // ---------------- gain compensation -------------------------------------
   d2yp_gain u_gain (
      .clock  (clock),
      .en     (en),
      .mag    (c1[N].x),
      .hyp_ff (hyp)
   );

   // ---------------- second CORDIC: atan2(dy, hyp) -------------------------
   d2yp_prep u_prep2 (
      .clock  (clock),
      .en     (en),
      .x_in   (hyp),
      .y_in   (dy_line_ff[d2yp_pkg::SIDE_LEN-1]),
      .vec_ff (c2[0])
   );

   for (genvar i = 0; i < N; i++) begin : g_chain2
      d2yp_cell u_cell (
         .clock  (clock),
         .en     (en),
         .idx    (d2yp_pkg::IDX_W'(i)),
         .vec_in (c2[i]),
         .vec_ff (c2[i+1])
      );
   end

   // side lines: dy waits for the magnitude, yaw waits for pitch
   always_ff @(posedge clock) begin
      if (en) begin
         dy_line_ff[0]  <= dy_ff;
         yaw_line_ff[0] <= yaw_sat[d2yp_pkg::YAW_W-1:0];
         for (int k = 1; k < d2yp_pkg::SIDE_LEN; k++) begin
            dy_line_ff[k]  <= dy_line_ff[k-1];
            yaw_line_ff[k] <= yaw_line_ff[k-1];
         end
      end
   end

   always_comb begin
      a2         = c2[N].zero ? '0 : c2[N].z;
      pitch_full = -(AW + 1)'(a2);
      if (pitch_full < -d2yp_pkg::PITCH_LIM) begin
         pitch_sat = -d2yp_pkg::PITCH_LIM;
      end else if (pitch_full > d2yp_pkg::PITCH_LIM) begin
         pitch_sat = d2yp_pkg::PITCH_LIM;
      end else begin
         pitch_sat = pitch_full;
      end
      pipe_rsp.pitch = pitch_sat[d2yp_pkg::PITCH_W-1:0];
      pipe_rsp.yaw   = yaw_line_ff[d2yp_pkg::SIDE_LEN-1];
   end

   // ---------------- valid bits --------------------------------------------
   assign valid_in = {valid_ff[d2yp_pkg::PIPE_LEN-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   // ---------------- output register and skid ------------------------------
   assign pipe_valid = valid_ff[d2yp_pkg::PIPE_LEN-1] && en;
   assign out_hold   = rsp_tvalid_ff && !rsp_tready;

   always_comb begin
      out_in        = out_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_hold) begin
         if (pipe_valid) begin
            skid_in       = pipe_rsp;
            skid_valid_in = 1'b1;
         end
      end else if (skid_valid_ff) begin
         out_in        = skid_ff;
         rsp_tvalid_in = 1'b1;
         skid_valid_in = 1'b0;
      end else begin
         out_in        = pipe_rsp;
         rsp_tvalid_in = pipe_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = d2yp_pkg::RSP_W'(out_ff);

`ifndef NO_ASSERTIONS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_tvalid_ff)
      else $error("skid holds an item while the output register is empty");

   a_skid_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_tvalid_ff && !rsp_tready))
      else $error("skid filled without an output stall");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_tready) |=> (rsp_tvalid_ff && !skid_valid_ff))
      else $error("skid item lost on drain");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> valid_ff[0])
      else $error("accepted item did not enter the pipe");

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> ((AW + 1)'(out_ff.yaw) >= d2yp_pkg::YAW_MIN
                      && (AW + 1)'(out_ff.yaw) <= d2yp_pkg::YAW_MAX
                      && (AW + 1)'(out_ff.pitch) >= -d2yp_pkg::PITCH_LIM
                      && (AW + 1)'(out_ff.pitch) <= d2yp_pkg::PITCH_LIM))
      else $error("result angle outside its saturation range");
`endif

endmodule

`default_nettype wire
